### hw/rtl/plc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int CODE_LEN_DEFAULT = 4;
    localparam int BYTE_W           = 8;
    localparam int ATTEMPT_W        = 4;
    localparam int EVENT_W          = 3;
    localparam int MODE_W           = 3;

    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RESET = 4'd3;

    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_UNLOCK    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_WRONG     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ALARM     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_MENU      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CHANGED   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_OLD_BAD   = 3'd6;
    localparam logic [EVENT_W-1:0] EV_MENU_LEFT = 3'd7;

    localparam logic [MODE_W-1:0] M_ENTRY   = 3'd0;
    localparam logic [MODE_W-1:0] M_REENTRY = 3'd1;
    localparam logic [MODE_W-1:0] M_MENU    = 3'd2;
    localparam logic [MODE_W-1:0] M_OLD     = 3'd3;
    localparam logic [MODE_W-1:0] M_NEW     = 3'd4;

    localparam logic [BYTE_W-1:0] KEY_MENU   = 8'h73;
    localparam logic [BYTE_W-1:0] KEY_CHANGE = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_TWO   = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_THREE = 8'h33;

    typedef logic [63:0] code_word_t;

    // The factory code repeats "23" over len bytes, first character in the highest one.
    function automatic code_word_t plc_init_code(input int len);
        code_word_t c;
        c = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (k < len)
            begin
                c = {c[55:0], (k % 2 == 1) ? CHAR_THREE : CHAR_TWO};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/plc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface plc_in_if;
    import plc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/plc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface plc_out_if;
    import plc_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [MODE_W-1:0]  mode_now;

    modport source (output valid, output event_res, output mode_now, input ready);
    modport sink (input valid, input event_res, input mode_now, output ready);
endinterface

`default_nettype wire

### hw/rtl/password_lock_controller.sv
// Password lock controller.
// Channel rx carries one received keypad byte per item; channel res carries
// exactly one result item per byte: the event it caused and the mode after it.
// Bytes form groups of CODE_LEN code bytes plus one ignored terminator byte.
// The byte is decoded against the lock state in the cycle it is accepted, and
// its result is written to the output register at the end of that cycle.
// One item is taken every cycle while rx.valid holds and results are taken:
// rx.ready is high whenever the output register is empty or is being read
// in the same cycle, so the rate is set by the single output register alone.
// When the receiver stalls, the result item holds and rx.ready drops until it
// is taken; no item is lost or repeated.
// Reset puts the lock in entry mode with an empty entry buffer, a zero
// failure count, the factory code "2323" and max_attempts of 3, and empties
// the output register. The user writes max_attempts through cfg_we and
// cfg_wdata only while the lock is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module password_lock_controller #(
    parameter int CODE_LEN = plc_pkg::CODE_LEN_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [plc_pkg::ATTEMPT_W-1:0]  cfg_wdata,
    plc_in_if.sink                              rx,
    plc_out_if.source                           res
);
    import plc_pkg::*;

    localparam int         CW        = BYTE_W * CODE_LEN;
    localparam int         PW        = $clog2(CODE_LEN + 1);
    localparam code_word_t INIT_CODE = plc_init_code(CODE_LEN);

    logic [ATTEMPT_W-1:0] max_attempts_reg;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        buf_reg, buf_next;
    logic [CW-1:0]        code_reg, code_next;
    logic [ATTEMPT_W-1:0] fail_reg, fail_next;

    logic                 res_valid_reg;
    logic [EVENT_W-1:0]   ev_reg, ev_next;
    logic [MODE_W-1:0]    mode_now_reg;

    logic                 accept;
    logic                 group_done;
    logic                 code_match;
    logic [CW-1:0]        buf_take;
    logic [PW-1:0]        pos_take;
    logic [ATTEMPT_W-1:0] fail_inc;
    logic [EVENT_W-1:0]   judge_ev;
    logic [MODE_W-1:0]    judge_mode;
    logic [ATTEMPT_W-1:0] judge_fail;

    assign rx.ready      = !res_valid_reg || res.ready;
    assign accept        = rx.valid && rx.ready;
    assign res.valid     = res_valid_reg;
    assign res.event_res = ev_reg;
    assign res.mode_now  = mode_now_reg;

    // The terminator byte closes a group and leaves the entry buffer as is.
    assign group_done = (pos_reg >= PW'(CODE_LEN));
    assign code_match = (buf_reg == code_reg);
    assign buf_take   = group_done ? buf_reg : ((buf_reg << BYTE_W) | CW'(rx.rx_byte));
    assign pos_take   = group_done ? '0 : pos_reg + PW'(1);
    assign fail_inc   = fail_reg + ATTEMPT_W'(1);

    always_comb
    begin
        if (code_match)
        begin
            judge_ev   = EV_UNLOCK;
            judge_mode = M_ENTRY;
            judge_fail = '0;
        end
        else if (fail_inc >= max_attempts_reg)
        begin
            judge_ev   = EV_ALARM;
            judge_mode = M_ENTRY;
            judge_fail = '0;
        end
        else
        begin
            judge_ev   = EV_WRONG;
            judge_mode = M_REENTRY;
            judge_fail = fail_inc;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        buf_next  = buf_reg;
        code_next = code_reg;
        fail_next = fail_reg;
        ev_next   = EV_NONE;
        case (mode_reg)
            M_MENU:
            begin
                if (rx.rx_byte == KEY_CHANGE)
                begin
                    mode_next = M_OLD;
                end
                else
                begin
                    mode_next = M_ENTRY;
                    ev_next   = EV_MENU_LEFT;
                end
                pos_next = '0;
                buf_next = '0;
            end
            M_REENTRY:
            begin
                buf_next = buf_take;
                pos_next = pos_take;
                if (group_done)
                begin
                    mode_next = judge_mode;
                    fail_next = judge_fail;
                    ev_next   = judge_ev;
                end
            end
            M_OLD:
            begin
                buf_next = buf_take;
                pos_next = pos_take;
                if (group_done)
                begin
                    if (code_match)
                    begin
                        mode_next = M_NEW;
                    end
                    else
                    begin
                        mode_next = M_ENTRY;
                        ev_next   = EV_OLD_BAD;
                    end
                end
            end
            M_NEW:
            begin
                buf_next = buf_take;
                pos_next = pos_take;
                if (group_done)
                begin
                    code_next = buf_reg;
                    mode_next = M_ENTRY;
                    ev_next   = EV_CHANGED;
                end
            end
            default:
            begin
                if (pos_reg == '0 && rx.rx_byte == KEY_MENU)
                begin
                    mode_next = M_MENU;
                    buf_next  = '0;
                    ev_next   = EV_MENU;
                end
                else
                begin
                    mode_next = M_ENTRY;
                    buf_next  = buf_take;
                    pos_next  = pos_take;
                    if (group_done)
                    begin
                        mode_next = judge_mode;
                        fail_next = judge_fail;
                        ev_next   = judge_ev;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
            mode_reg         <= M_ENTRY;
            pos_reg          <= '0;
            buf_reg          <= '0;
            code_reg         <= INIT_CODE[CW-1:0];
            fail_reg         <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_attempts_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg      <= mode_next;
                pos_reg       <= pos_next;
                buf_reg       <= buf_next;
                code_reg      <= code_next;
                fail_reg      <= fail_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg       <= ev_next;
            mode_now_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire
